### rtl/bgd_pkg.sv
// bgd_pkg: shared types and constants for the button gesture detector
// holds the transaction payload structs and configuration register indexes
// no dependencies
package bgd_pkg;

  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  // configuration register indexes
  localparam cfg_index_t REG_TAP_WINDOW = 1'd0;
  localparam cfg_index_t REG_LONG_PRESS = 1'd1;

  // reset values of the configuration registers
  localparam cfg_data_t TAP_WINDOW_RESET = 16'd300;
  localparam cfg_data_t LONG_PRESS_RESET = 16'd1000;

  // count that flags a double tap
  localparam int unsigned DOUBLE_TAP_COUNT = 2;

  typedef struct packed {
    logic        level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       held;
    logic       pressed_event;
    logic       released_event;
    logic       double_tap;
    logic       long_press;
    logic [3:0] clicks;
  } out_t;

endpackage

### rtl/bgd_track.sv
// bgd_track: gesture state registers and the per-sample update logic
// depends on bgd_pkg
module bgd_track #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bgd_pkg::in_t      sample,
  input  bgd_pkg::cfg_data_t tap_window_ms,
  input  bgd_pkg::cfg_data_t long_press_ms,
  output bgd_pkg::out_t     result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  prev_level;
  logic [COUNT_BITS-1:0] click_total;
  logic [TIME_BITS-1:0]  last_click_time;
  logic [TIME_BITS-1:0]  press_start_time;
  logic                  long_reported;

  logic                  prev_level_next;
  logic [COUNT_BITS-1:0] click_total_next;
  logic [TIME_BITS-1:0]  last_click_time_next;
  logic [TIME_BITS-1:0]  press_start_time_next;
  logic                  long_reported_next;

  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  tap_win;
  logic [TIME_BITS-1:0]  long_thr;
  logic [TIME_BITS-1:0]  since_click;
  logic [TIME_BITS-1:0]  since_press;
  logic [COUNT_BITS-1:0] count_kept;
  logic [COUNT_BITS-1:0] count_pressed;
  logic                  rise;
  logic                  fall;
  logic                  dbl;
  logic                  lp;

  always_comb begin
    now         = TIME_BITS'(sample.now_ms);
    tap_win     = TIME_BITS'(tap_window_ms);
    long_thr    = TIME_BITS'(long_press_ms);
    since_click = now - last_click_time;
    rise        = sample.level && !prev_level;
    fall        = !sample.level && prev_level;

    // sequence times out only while released
    if ((click_total != '0) && !prev_level && (since_click > tap_win)) begin
      count_kept = '0;
    end else begin
      count_kept = click_total;
    end

    if (since_click < tap_win) begin
      count_pressed = (count_kept < COUNT_MAX) ? count_kept + 1'b1 : count_kept;
    end else begin
      count_pressed = COUNT_BITS'(1);
    end

    if (rise) begin
      click_total_next      = count_pressed;
      press_start_time_next = now;
      last_click_time_next  = now;
      long_reported_next    = 1'b0;
    end else begin
      click_total_next      = count_kept;
      press_start_time_next = press_start_time;
      last_click_time_next  = last_click_time;
      long_reported_next    = long_reported;
    end
    dbl = rise && (count_pressed == COUNT_BITS'(bgd_pkg::DOUBLE_TAP_COUNT));

    // long press check runs after the edge logic
    since_press = now - press_start_time_next;
    lp = sample.level && !long_reported_next && (since_press >= long_thr);
    if (lp) begin
      long_reported_next = 1'b1;
      click_total_next   = '0;
    end
    prev_level_next = sample.level;

    result.held           = sample.level;
    result.pressed_event  = rise;
    result.released_event = fall;
    result.double_tap     = dbl;
    result.long_press     = lp;
    result.clicks         = 4'(click_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level       <= 1'b0;
      click_total      <= '0;
      last_click_time  <= '0;
      press_start_time <= '0;
      long_reported    <= 1'b0;
    end else if (step) begin
      prev_level       <= prev_level_next;
      click_total      <= click_total_next;
      last_click_time  <= last_click_time_next;
      press_start_time <= press_start_time_next;
      long_reported    <= long_reported_next;
    end
  end

endmodule

### rtl/button_gesture_detector.sv
// button_gesture_detector: top level with handshake stages and config registers
// depends on bgd_pkg and bgd_track
//
// Takes one button poll (level plus a wrapping millisecond timestamp) per
// transaction and returns one result per transaction: the held level, rising
// and falling edge flags, a double tap flag when a press makes the click count
// exactly two, a once-per-press long press flag, and the saturating click
// count. Presses closer than tap_window_ms (register 0, reset 300) extend a
// click sequence; the count clears once the window has passed with the button
// released, and a long press (hold of long_press_ms, register 1, reset 1000)
// also clears it. Only the low TIME_BITS bits of the timestamp are used and
// all time differences wrap. A transaction is registered at the input, goes
// through one pass of compare and subtract logic against the gesture state,
// and lands in the output register. One transaction is taken every cycle as
// long as the output side keeps taking results. Configuration writes must be
// made while no transaction is in flight.
module button_gesture_detector #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgd_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgd_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  bgd_pkg::cfg_index_t cfg_index,
  input  bgd_pkg::cfg_data_t  cfg_data
);

  // configuration registers
  bgd_pkg::cfg_data_t tap_window_ms;
  bgd_pkg::cfg_data_t long_press_ms;

  // input register stage
  logic         stage_valid;
  bgd_pkg::in_t stage_data;

  logic          stage_adv;
  bgd_pkg::out_t result;

  // stage moves forward when the output register is empty or being drained
  assign stage_adv = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_window_ms <= bgd_pkg::TAP_WINDOW_RESET;
      long_press_ms <= bgd_pkg::LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgd_pkg::REG_TAP_WINDOW: tap_window_ms <= cfg_data;
        bgd_pkg::REG_LONG_PRESS: long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  // gesture state updates exactly once per transaction, when it leaves the stage
  bgd_track #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .step         (stage_adv),
    .sample       (stage_data),
    .tap_window_ms(tap_window_ms),
    .long_press_ms(long_press_ms),
    .result       (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_data <= result;
    end
  end

  // a long press only happens while the button is down
  a_long_needs_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.long_press || out_data.held))
    else $error("long press reported with button released");

  // edges agree with the reported level and never coincide
  a_edges_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(out_data.pressed_event && out_data.released_event) &&
                   (!out_data.pressed_event || out_data.held) &&
                   (!out_data.released_event || !out_data.held)))
    else $error("edge flags inconsistent with held level");

  // a double tap is only flagged on a press
  a_double_on_press: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.double_tap || out_data.pressed_event))
    else $error("double tap without a press");

  // a stalled output with a full stage must block new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is full");

endmodule

### verif/button_gesture_detector_test.sv
// button_gesture_detector_test: self-checking testbench for the button gesture detector
// predicts every result transaction from its own gesture model and compares field by field
// depends on bgd_pkg and the button_gesture_detector rtl
module button_gesture_detector_test;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_POLLS = 205;   // random polls per configuration phase
  localparam int unsigned IDLE_PCT    = 32;    // chance of an idle cycle on either side
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no transaction before giving up
  localparam int unsigned DRAIN_WAIT  = 8;     // settling margin after the last expected result
  localparam int unsigned SHOWN_MAX   = 30;    // mismatch lines printed before going quiet

  // scoreboard: gesture predictor plus queue of expected result transactions
  class gesture_scoreboard;
    bgd_pkg::cfg_data_t tap_window;
    bgd_pkg::cfg_data_t long_hold;
    logic               prev_level;
    logic [3:0]         click_total;
    logic [31:0]        last_click;
    logic [31:0]        press_start;
    logic               long_done;
    bgd_pkg::out_t      expected_gestures[$];
    int unsigned        errors;
    int unsigned        results_seen;

    function new();
      tap_window   = bgd_pkg::TAP_WINDOW_RESET;
      long_hold    = bgd_pkg::LONG_PRESS_RESET;
      prev_level   = 1'b0;
      click_total  = '0;
      last_click   = '0;
      press_start  = '0;
      long_done    = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(bgd_pkg::cfg_index_t idx, bgd_pkg::cfg_data_t value);
      case (idx)
        bgd_pkg::REG_TAP_WINDOW: tap_window = value;
        bgd_pkg::REG_LONG_PRESS: long_hold  = value;
        default: ;
      endcase
    endfunction

    // one poll through the gesture logic; all time differences wrap at 32 bits
    function bgd_pkg::out_t gesture_step(bgd_pkg::in_t poll);
      bgd_pkg::out_t res;
      logic [31:0]   since_click;
      logic [31:0]   held_for;
      res = '0;
      since_click = poll.now_ms - last_click;
      // sequence times out only while released
      if (click_total != 0 && !prev_level && since_click > 32'(tap_window))
        click_total = '0;
      if (poll.level && !prev_level) begin
        res.pressed_event = 1'b1;
        press_start = poll.now_ms;
        long_done = 1'b0;
        if (since_click < 32'(tap_window)) begin
          if (click_total != '1)
            click_total = click_total + 1'b1;
        end else begin
          click_total = 4'd1;
        end
        last_click = poll.now_ms;
        if (click_total == 4'(bgd_pkg::DOUBLE_TAP_COUNT))
          res.double_tap = 1'b1;
      end else if (!poll.level && prev_level) begin
        res.released_event = 1'b1;
      end
      prev_level = poll.level;
      // long press check runs after the edge logic and wipes the count
      held_for = poll.now_ms - press_start;
      if (poll.level && !long_done && held_for >= 32'(long_hold)) begin
        long_done = 1'b1;
        click_total = '0;
        res.long_press = 1'b1;
      end
      res.held = poll.level;
      res.clicks = click_total;
      return res;
    endfunction

    function void note_poll(bgd_pkg::in_t poll);
      expected_gestures.push_back(gesture_step(poll));
    endfunction

    function int unsigned pending();
      return expected_gestures.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < SHOWN_MAX)
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 what, results_seen, got, want);
      errors++;
    endtask

    task check_result(bgd_pkg::out_t got);
      bgd_pkg::out_t want;
      if (expected_gestures.size() == 0) begin
        report("unexpected result", 32'(got), '0);
        results_seen++;
        return;
      end
      want = expected_gestures.pop_front();
      if (got.held !== want.held)
        report("held", 32'(got.held), 32'(want.held));
      if (got.pressed_event !== want.pressed_event)
        report("pressed_event", 32'(got.pressed_event), 32'(want.pressed_event));
      if (got.released_event !== want.released_event)
        report("released_event", 32'(got.released_event), 32'(want.released_event));
      if (got.double_tap !== want.double_tap)
        report("double_tap", 32'(got.double_tap), 32'(want.double_tap));
      if (got.long_press !== want.long_press)
        report("long_press", 32'(got.long_press), 32'(want.long_press));
      if (got.clicks !== want.clicks)
        report("clicks", 32'(got.clicks), 32'(want.clicks));
      results_seen++;
    endtask
  endclass

  // everything the block sees starts at a known value
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bgd_pkg::in_t        in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bgd_pkg::out_t       out_data;
  logic                cfg_we = 1'b0;
  bgd_pkg::cfg_index_t cfg_index = bgd_pkg::REG_TAP_WINDOW;
  bgd_pkg::cfg_data_t  cfg_data = '0;

  gesture_scoreboard sb = new();

  logic [31:0] now_ms = '0;       // running poll time used by the sequence tasks
  int unsigned polls_sent = 0;
  bit          calm = 1'b0;       // no idling on either side while set
  int unsigned quiet_cycles = 0;

  button_gesture_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side backpressure, one decision per cycle
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // transaction monitor: inputs feed the predictor, outputs are checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_poll(in_data);
      if (out_valid && out_ready)
        sb.check_result(out_data);
    end
  end

  // watchdog: too long without any transaction on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("button_gesture_detector_test: errors");
        $finish;
      end
    end
  end

  // gap picker that clusters around a threshold: below, at, just above, far beyond
  function automatic logic [31:0] gap_near(logic [31:0] limit);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, limit);
      1: return limit - 1;
      2: return limit;
      3: return limit + 1;
      4: return limit + $urandom_range(0, limit + 16);
      default: return $urandom_range(0, limit / 2);
    endcase
  endfunction

  // one poll transaction; valid holds with a steady payload until taken
  task automatic poll(logic level, logic [31:0] at);
    bgd_pkg::in_t item;
    item.level = level;
    item.now_ms = at;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    polls_sent++;
  endtask

  // both registers in two back-to-back writes, block idle
  task automatic configure(bgd_pkg::cfg_data_t tap, bgd_pkg::cfg_data_t hold);
    cfg_we <= 1'b1;
    cfg_index <= bgd_pkg::REG_TAP_WINDOW;
    cfg_data <= tap;
    @(posedge clk);
    sb.write_reg(bgd_pkg::REG_TAP_WINDOW, tap);
    cfg_index <= bgd_pkg::REG_LONG_PRESS;
    cfg_data <= hold;
    @(posedge clk);
    sb.write_reg(bgd_pkg::REG_LONG_PRESS, hold);
    cfg_we <= 1'b0;
  endtask

  // wait until every expected result is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // burst of taps, press-to-press gaps straddling the tap window
  task automatic tap_burst();
    int unsigned taps;
    logic [31:0] gap;
    logic [31:0] up_for;
    taps = $urandom_range(1, 20);
    repeat (taps) begin
      gap = gap_near(32'(sb.tap_window));
      up_for = $urandom_range(0, gap);
      poll(1'b1, now_ms);
      if ($urandom_range(0, 3) == 0)
        poll(1'b1, now_ms + up_for / 2);
      poll(1'b0, now_ms + up_for);
      now_ms = now_ms + gap;
    end
  endtask

  // one press held around the long press threshold, then released
  task automatic long_hold_seq();
    logic [31:0] press_at;
    int unsigned checks;
    press_at = now_ms;
    checks = $urandom_range(1, 4);
    poll(1'b1, press_at);
    repeat (checks)
      poll(1'b1, press_at + gap_near(32'(sb.long_hold)));
    now_ms = press_at + 32'(sb.long_hold) + $urandom_range(0, 50);
    poll(1'b0, now_ms);
  endtask

  // released polls that let the tap window run out or not
  task automatic idle_seq();
    repeat ($urandom_range(1, 4)) begin
      now_ms = now_ms + gap_near(32'(sb.tap_window));
      poll(1'b0, now_ms);
    end
  endtask

  // random levels with random or jumping timestamps
  task automatic noise_seq();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 0)
        now_ms = $urandom;
      else
        now_ms = now_ms + $urandom_range(0, 3 * sb.tap_window + 3);
      poll(1'($urandom_range(0, 1)), now_ms);
    end
  endtask

  // mostly well-formed gestures with random timing, some noise
  task automatic random_phase();
    int unsigned goal;
    goal = polls_sent + PHASE_POLLS;
    if ($urandom_range(0, 1) == 0)
      now_ms = $urandom;
    else
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);  // crosses the wrap
    while (polls_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: tap_burst();
        5, 6:          long_hold_seq();
        7:             idle_seq();
        default:       noise_seq();
      endcase
    end
  endtask

  initial begin
    bgd_pkg::cfg_data_t tap_set[PHASES];
    bgd_pkg::cfg_data_t hold_set[PHASES];
    // phase 0 runs on reset values; phase 3 is the stretch with no idling
    tap_set  = '{16'd300, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd40,    16'd65535, 16'd300};
    hold_set = '{16'd1000, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd65535, 16'd0,     16'd1000};
    tap_set[4]  = 16'($urandom_range(0, 65535));
    hold_set[4] = 16'($urandom_range(0, 65535));
    hold_set[7] = 16'($urandom_range(1, 2000));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed gestures on reset settings
    poll(1'b0, 32'd0);            // released from the start
    poll(1'b1, 32'd100);          // first click
    poll(1'b0, 32'd150);
    poll(1'b1, 32'd200);          // double tap
    poll(1'b0, 32'd250);
    poll(1'b0, 32'd700);          // window expired while released
    poll(1'b1, 32'd800);
    poll(1'b1, 32'd1500);
    poll(1'b1, 32'd1800);         // long press exactly at threshold
    poll(1'b1, 32'd2500);         // reported once only
    poll(1'b0, 32'd2600);
    poll(1'b1, 32'd2700);
    poll(1'b1, 32'd3200);         // window expired but still held
    poll(1'b0, 32'd3300);         // release step keeps the count
    poll(1'b0, 32'd3400);         // next released step clears it
    poll(1'b1, 32'hFFFF_FF00);    // taps across the timestamp wrap
    poll(1'b0, 32'hFFFF_FF80);
    poll(1'b1, 32'h0000_0010);
    poll(1'b1, 32'h0000_0400);    // long press after the press just past the wrap
    poll(1'b0, 32'hFFFF_FFFF);
    poll(1'b1, 32'h7FFF_FFFF);
    poll(1'b0, 32'h8000_0000);

    random_phase();
    for (int p = 1; p < PHASES; p++) begin
      drain();
      calm = (p == 3);
      configure(tap_set[p], hold_set[p]);
      random_phase();
    end
    drain();

    if (sb.errors == 0)
      $display("button_gesture_detector_test: clean");
    else
      $display("button_gesture_detector_test: errors");
    $finish;
  end

endmodule

### button_gesture_detector.f
rtl/bgd_pkg.sv
rtl/bgd_track.sv
rtl/button_gesture_detector.sv
verif/button_gesture_detector_test.sv
